### rtl/polyline_splitter_top_defines.svh
// Assertion macros for the polyline splitter
`ifndef POLYLINE_SPLITTER_TOP_DEFINES_SVH
`define POLYLINE_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pls_pkg.sv
`default_nettype none
package pls_pkg;
  localparam int CoordW   = 48;
  localparam int LenW     = 48;
  localparam int FracBits = 16;
  localparam int MaxCuts  = 63;
  localparam int CntW     = 6;
  localparam int SrcW     = 98;
  localparam int RemW     = 52;
  localparam int ModeW    = 3;
  localparam int DivCntW  = 16;
  localparam int CfgIdxW  = 2;

  localparam logic [LenW-1:0] LenMax = '1;
  localparam logic [LenW-1:0] PieceLengthRst = LenW'(5) << FracBits;
  localparam logic [DivCntW-1:0] DivCountRst = DivCntW'(5);

  localparam logic [CfgIdxW-1:0] CFG_SPLIT_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIECE_LENGTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIVISION_COUNT = 2'd2;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CUT    = 2'd1;
  localparam logic [1:0] KIND_VERTEX = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [ModeW-1:0] MODE_FULL  = 3'd0;
  localparam logic [ModeW-1:0] MODE_CARRY = 3'd1;
  localparam logic [ModeW-1:0] MODE_EVEN  = 3'd2;
  localparam logic [ModeW-1:0] MODE_COUNT = 3'd3;
  localparam logic [ModeW-1:0] MODE_HALF  = 3'd4;

  typedef struct packed {
    logic            start;
    logic [1:0]      op;
    logic [SrcW-1:0] opa;
    logic [LenW-1:0] opb;
  } unit_cmd_t;

  typedef struct packed {
    logic            done;
    logic [SrcW-1:0] q;
    logic [RemW-1:0] r;
  } unit_res_t;
endpackage
`default_nettype wire

### rtl/pls_in_if.sv
`default_nettype none
interface pls_in_if;
  import pls_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x;
  logic signed [CoordW-1:0] y;
  logic signed [CoordW-1:0] z;
  logic signed [CoordW-1:0] m;
  logic                     first_in_part;
  logic                     last_in_part;
  logic [LenW-1:0]          part_length;
  modport source (output valid, x, y, z, m, first_in_part, last_in_part, part_length,
                  input ready);
  modport sink (input valid, x, y, z, m, first_in_part, last_in_part, part_length,
                output ready);
endinterface
`default_nettype wire

### rtl/pls_out_if.sv
`default_nettype none
interface pls_out_if;
  import pls_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               point_kind;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic signed [CoordW-1:0] out_m;
  logic                     last_of_run;
  logic                     cut_overflow;
  modport source (output valid, point_kind, out_x, out_y, out_z, out_m, last_of_run,
                  cut_overflow, input ready);
  modport sink (input valid, point_kind, out_x, out_y, out_z, out_m, last_of_run,
                cut_overflow, output ready);
endinterface
`default_nettype wire

### rtl/polyline_splitter_top.sv
`default_nettype none
// Polyline splitter: takes line vertices one word at a time and returns piece starts,
// cut points and vertices, cutting each part by length or by division count. All
// multiplies, divides and square roots run through one shared unit that settles one
// bit per cycle. Each cut point on a segment takes four interpolations, each a
// multiply and a divide. The input is not ready while a vertex is in work; a
// finished result waits in an output register without holding up the next vertex.
// Once a segment starts with a zero target the block answers every vertex with an
// error word until reset.
module polyline_splitter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  pls_in_if.sink                        in_ch,
  pls_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pls_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pls_pkg::LenW-1:0]      cfg_wdata
);
  import pls_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_WAIT   = 4'd2;
  localparam logic [3:0] S_FDIV   = 4'd3;
  localparam logic [3:0] S_FSTART = 4'd4;
  localparam logic [3:0] S_SQY    = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_LEN    = 4'd7;
  localparam logic [3:0] S_LOOP   = 4'd8;
  localparam logic [3:0] S_OVF    = 4'd9;
  localparam logic [3:0] S_OVFR   = 4'd10;
  localparam logic [3:0] S_IMUL   = 4'd11;
  localparam logic [3:0] S_IDIV   = 4'd12;
  localparam logic [3:0] S_IRES   = 4'd13;
  localparam logic [3:0] S_VERT   = 4'd14;
  localparam logic [3:0] S_PUSH   = 4'd15;

  logic [3:0]               state_r;
  logic [3:0]               ret_r;
  logic [ModeW-1:0]         split_mode_r;
  logic [LenW-1:0]          piece_length_r;
  logic [DivCntW-1:0]       division_count_r;

  logic signed [CoordW-1:0] cur_x_r, cur_y_r, cur_z_r, cur_m_r;
  logic                     cur_first_r, cur_last_r;
  logic [LenW-1:0]          cur_plen_r;
  logic signed [CoordW-1:0] prev_x_r, prev_y_r, prev_z_r, prev_m_r;
  logic [LenW-1:0]          carried_r, target_r, default_r;
  logic                     sp_r, halted_r;

  logic [SrcW-1:0]          sum_r;
  logic [LenW-1:0]          len_r, rem_r, dist_r;
  logic [CntW-1:0]          n_r;
  logic                     ovf_r;
  logic [1:0]               idx_r;
  logic signed [CoordW-1:0] cut_r [3];

  logic [1:0]               pend_kind_r;
  logic signed [CoordW-1:0] pend_x_r, pend_y_r, pend_z_r, pend_m_r;
  logic                     pend_last_r, pend_ovf_r;

  logic                     out_valid_r;
  logic [1:0]               out_kind_r;
  logic signed [CoordW-1:0] out_x_r, out_y_r, out_z_r, out_m_r;
  logic                     out_last_r, out_ovf_r;

  unit_cmd_t                cmd;
  unit_res_t                res;

  logic [ModeW-1:0]         md;
  logic [LenW-1:0]          mx, my;
  logic signed [CoordW-1:0] ia, ib, ival;
  logic [LenW-1:0]          idiff;
  logic                     ia_le;
  logic [LenW:0]            walk_sum;
  logic                     cut_go;
  logic [LenW-1:0]          stepd, rem_left;
  logic [LenW-1:0]          root_sat;
  logic [LenW-1:0]          carried_upd;

  pls_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
  );

  always_comb begin
    md = (split_mode_r > MODE_HALF) ? MODE_FULL : split_mode_r;
    mx = (prev_x_r <= cur_x_r) ? LenW'(cur_x_r - prev_x_r) : LenW'(prev_x_r - cur_x_r);
    my = (prev_y_r <= cur_y_r) ? LenW'(cur_y_r - prev_y_r) : LenW'(prev_y_r - cur_y_r);
    case (idx_r)
      2'd0:    begin ia = prev_x_r; ib = cur_x_r; end
      2'd1:    begin ia = prev_y_r; ib = cur_y_r; end
      2'd2:    begin ia = prev_z_r; ib = cur_z_r; end
      default: begin ia = prev_m_r; ib = cur_m_r; end
    endcase
    ia_le = ia <= ib;
    idiff = ia_le ? LenW'(ib - ia) : LenW'(ia - ib);
    if (len_r == '0)
      ival = ia;
    else if (ia_le)
      ival = ia + CoordW'(res.q[LenW-1:0]);
    else
      ival = ia - CoordW'(res.q[LenW-1:0]);
    walk_sum    = {1'b0, rem_r} + {1'b0, carried_r};
    cut_go      = walk_sum > {1'b0, target_r};
    stepd       = (carried_r < target_r) ? target_r - carried_r : '0;
    rem_left    = rem_r - stepd;
    root_sat    = res.q[LenW] ? LenMax : res.q[LenW-1:0];
    carried_upd = walk_sum[LenW] ? LenMax : walk_sum[LenW-1:0];
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    cmd.opa   = '0;
    cmd.opb   = '0;
    unique case (state_r)
      S_DISP: begin
        if (!halted_r && cur_first_r) begin
          cmd.op  = OP_DIV;
          cmd.opa = SrcW'(cur_plen_r);
          if (md == MODE_EVEN) begin
            cmd.start = piece_length_r != '0;
            cmd.opb   = piece_length_r;
          end else if (md == MODE_COUNT) begin
            cmd.start = 1'b1;
            cmd.opb   = LenW'(division_count_r) + LenW'(1);
          end else if (md == MODE_HALF) begin
            cmd.start = division_count_r != '0;
            cmd.opb   = LenW'(division_count_r);
          end
        end else if (!halted_r && target_r != '0) begin
          cmd.start = 1'b1;
          cmd.opa   = SrcW'(mx);
          cmd.opb   = mx;
        end
      end
      S_SQY: begin
        cmd.start = 1'b1;
        cmd.opa   = SrcW'(my);
        cmd.opb   = my;
      end
      S_SQRT: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.opa   = sum_r + res.q;
      end
      S_OVF: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.opa   = SrcW'(rem_r - LenW'(1));
        cmd.opb   = target_r;
      end
      S_IMUL: begin
        cmd.start = 1'b1;
        cmd.opa   = SrcW'(idiff);
        cmd.opb   = dist_r;
      end
      S_IDIV: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.opa   = res.q;
        cmd.opb   = len_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      ret_r            <= S_IDLE;
      split_mode_r     <= MODE_FULL;
      piece_length_r   <= PieceLengthRst;
      division_count_r <= DivCountRst;
      prev_x_r         <= '0;
      prev_y_r         <= '0;
      prev_z_r         <= '0;
      prev_m_r         <= '0;
      carried_r        <= '0;
      target_r         <= '0;
      default_r        <= '0;
      sp_r             <= 1'b0;
      halted_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPLIT_MODE:     split_mode_r     <= cfg_wdata[ModeW-1:0];
          CFG_PIECE_LENGTH:   piece_length_r   <= cfg_wdata;
          CFG_DIVISION_COUNT: division_count_r <= cfg_wdata[DivCntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && state_r != S_PUSH)
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_x_r     <= in_ch.x;
            cur_y_r     <= in_ch.y;
            cur_z_r     <= in_ch.z;
            cur_m_r     <= in_ch.m;
            cur_first_r <= in_ch.first_in_part;
            cur_last_r  <= in_ch.last_in_part;
            cur_plen_r  <= in_ch.part_length;
            state_r     <= S_DISP;
          end
        end
        S_DISP: begin
          if (halted_r || (!cur_first_r && target_r == '0)) begin
            halted_r    <= 1'b1;
            pend_kind_r <= KIND_ERROR;
            pend_x_r    <= '0;
            pend_y_r    <= '0;
            pend_z_r    <= '0;
            pend_m_r    <= '0;
            pend_last_r <= 1'b1;
            pend_ovf_r  <= 1'b0;
            ret_r       <= S_IDLE;
            state_r     <= S_PUSH;
          end else if (cur_first_r) begin
            state_r <= cmd.start ? S_WAIT : S_FSTART;
            ret_r   <= S_FDIV;
            unique case (md)
              MODE_CARRY: begin
                sp_r      <= 1'b0;
                target_r  <= piece_length_r;
                default_r <= piece_length_r;
              end
              MODE_EVEN: begin
                sp_r      <= 1'b1;
                carried_r <= '0;
                default_r <= piece_length_r;
                target_r  <= '0;
              end
              MODE_COUNT: begin
                sp_r      <= 1'b0;
                carried_r <= '0;
              end
              MODE_HALF: begin
                sp_r      <= 1'b1;
                carried_r <= '0;
                default_r <= LenMax;
                target_r  <= LenMax >> 1;
              end
              default: begin
                sp_r      <= 1'b0;
                carried_r <= '0;
                target_r  <= piece_length_r;
                default_r <= piece_length_r;
              end
            endcase
          end else begin
            ret_r   <= S_SQY;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (res.done)
            state_r <= ret_r;
        end
        S_FDIV: begin
          case (md)
            MODE_EVEN: target_r <= res.r[LenW-1:0] >> 1;
            MODE_COUNT: begin
              target_r  <= res.q[LenW-1:0];
              default_r <= res.q[LenW-1:0];
            end
            default: begin
              target_r  <= res.q[LenW-1:0] >> 1;
              default_r <= res.q[LenW-1:0];
            end
          endcase
          state_r <= S_FSTART;
        end
        S_FSTART: begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          prev_z_r    <= cur_z_r;
          prev_m_r    <= cur_m_r;
          pend_kind_r <= KIND_START;
          pend_x_r    <= cur_x_r;
          pend_y_r    <= cur_y_r;
          pend_z_r    <= cur_z_r;
          pend_m_r    <= cur_m_r;
          pend_last_r <= 1'b1;
          pend_ovf_r  <= 1'b0;
          ret_r       <= S_IDLE;
          state_r     <= cur_last_r ? S_IDLE : S_PUSH;
        end
        S_SQY: begin
          sum_r   <= res.q;
          ret_r   <= S_SQRT;
          state_r <= S_WAIT;
        end
        S_SQRT: begin
          ret_r   <= S_LEN;
          state_r <= S_WAIT;
        end
        S_LEN: begin
          len_r   <= root_sat;
          rem_r   <= root_sat;
          n_r     <= '0;
          ovf_r   <= 1'b0;
          state_r <= S_LOOP;
        end
        S_LOOP: begin
          if (!cut_go) begin
            state_r <= S_VERT;
          end else if (n_r == CntW'(MaxCuts)) begin
            ovf_r     <= 1'b1;
            carried_r <= '0;
            if (target_r == '0) begin
              rem_r   <= '0;
              state_r <= S_VERT;
            end else begin
              state_r <= S_OVF;
            end
          end else begin
            rem_r     <= rem_left;
            dist_r    <= len_r - rem_left;
            carried_r <= '0;
            idx_r     <= 2'd0;
            state_r   <= S_IMUL;
          end
        end
        S_OVF: begin
          ret_r   <= S_OVFR;
          state_r <= S_WAIT;
        end
        S_OVFR: begin
          rem_r   <= res.r[LenW-1:0] + LenW'(1);
          state_r <= S_VERT;
        end
        S_IMUL: begin
          ret_r   <= S_IDIV;
          state_r <= S_WAIT;
        end
        S_IDIV: begin
          ret_r   <= S_IRES;
          state_r <= S_WAIT;
        end
        S_IRES: begin
          if (idx_r == 2'd3) begin
            pend_kind_r <= KIND_CUT;
            pend_x_r    <= cut_r[0];
            pend_y_r    <= cut_r[1];
            pend_z_r    <= cut_r[2];
            pend_m_r    <= ival;
            pend_last_r <= 1'b0;
            pend_ovf_r  <= 1'b0;
            n_r         <= n_r + CntW'(1);
            if (sp_r) begin
              sp_r     <= 1'b0;
              target_r <= default_r;
            end
            ret_r   <= S_LOOP;
            state_r <= S_PUSH;
          end else begin
            cut_r[idx_r] <= ival;
            idx_r        <= idx_r + 2'd1;
            state_r      <= S_IMUL;
          end
        end
        S_VERT: begin
          pend_kind_r <= KIND_VERTEX;
          pend_x_r    <= cur_x_r;
          pend_y_r    <= cur_y_r;
          pend_z_r    <= cur_z_r;
          pend_m_r    <= cur_m_r;
          pend_last_r <= 1'b1;
          pend_ovf_r  <= ovf_r;
          carried_r   <= carried_upd;
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          prev_z_r    <= cur_z_r;
          prev_m_r    <= cur_m_r;
          ret_r       <= S_IDLE;
          state_r     <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= pend_kind_r;
            out_x_r     <= pend_x_r;
            out_y_r     <= pend_y_r;
            out_z_r     <= pend_z_r;
            out_m_r     <= pend_m_r;
            out_last_r  <= pend_last_r;
            out_ovf_r   <= pend_ovf_r;
            state_r     <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.point_kind   = out_kind_r;
  assign out_ch.out_x        = out_x_r;
  assign out_ch.out_y        = out_y_r;
  assign out_ch.out_z        = out_z_r;
  assign out_ch.out_m        = out_m_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.cut_overflow = out_ovf_r;
endmodule
`default_nettype wire

### rtl/pls_unit.sv
`default_nettype none
module pls_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  pls_pkg::unit_cmd_t  cmd,
  output pls_pkg::unit_res_t  res
);
  import pls_pkg::*;

  localparam logic [6:0] MulLast  = 7'(LenW - 1);
  localparam logic [6:0] DivLast  = 7'(SrcW - 1);
  localparam logic [6:0] SqrtLast = 7'(SrcW / 2 - 1);

  logic            busy_r;
  logic            done_r;
  logic [1:0]      op_r;
  logic [6:0]      cnt_r;
  logic [SrcW-1:0] src_r;
  logic [SrcW-1:0] acc_r;
  logic [LenW-1:0] opb_r;
  logic [RemW-1:0] rem_r;
  logic [6:0]      last_cnt;

  logic [SrcW-1:0] mul_sum;
  logic [LenW:0]   div_t;
  logic [LenW:0]   div_d;
  logic            div_ge;
  logic [RemW-1:0] sq_t;
  logic [RemW-1:0] sq_trial;
  logic            sq_ge;

  always_comb begin
    mul_sum  = {acc_r[SrcW-2:0], 1'b0} + (opb_r[LenW-1] ? SrcW'(src_r[LenW-1:0]) : '0);
    div_t    = {rem_r[LenW-1:0], src_r[SrcW-1]};
    div_ge   = div_t >= {1'b0, opb_r};
    div_d    = div_t - {1'b0, opb_r};
    sq_t     = {rem_r[RemW-3:0], src_r[SrcW-1:SrcW-2]};
    sq_trial = {acc_r[RemW-3:0], 2'b01};
    sq_ge    = sq_t >= sq_trial;
    unique case (op_r)
      OP_MUL:  last_cnt = MulLast;
      OP_DIV:  last_cnt = DivLast;
      default: last_cnt = SqrtLast;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= cmd.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == last_cnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && cmd.start) begin
      src_r <= cmd.opa;
      opb_r <= cmd.opb;
      acc_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_r <= mul_sum;
          opb_r <= {opb_r[LenW-2:0], 1'b0};
        end
        OP_DIV: begin
          acc_r <= {acc_r[SrcW-2:0], div_ge};
          rem_r <= RemW'(div_ge ? div_d[LenW-1:0] : div_t[LenW-1:0]);
          src_r <= {src_r[SrcW-2:0], 1'b0};
        end
        default: begin
          acc_r <= {acc_r[SrcW-2:0], sq_ge};
          rem_r <= sq_ge ? sq_t - sq_trial : sq_t;
          src_r <= {src_r[SrcW-3:0], 2'b00};
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.q    = acc_r;
  assign res.r    = rem_r;
endmodule
`default_nettype wire

### rtl/pls_checker.sv
`default_nettype none
`include "polyline_splitter_top_defines.svh"
module pls_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    point_kind,
  input wire logic [pls_pkg::CoordW-1:0]    out_x,
  input wire logic                          last_of_run,
  input wire logic                          cut_overflow
);
  import pls_pkg::*;

  `PLS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `PLS_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "vertex taken while busy")
  `PLS_ASSERT_IMP(a_err_word, out_valid && point_kind == KIND_ERROR, last_of_run && out_x == '0 && !cut_overflow, "malformed error word")
  `PLS_ASSERT_IMP(a_ovf_vertex, out_valid && cut_overflow, point_kind == KIND_VERTEX && last_of_run, "overflow flag off a vertex word")
endmodule

bind polyline_splitter_top pls_checker u_pls_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .point_kind   (out_ch.point_kind),
  .out_x        (out_ch.out_x),
  .last_of_run  (out_ch.last_of_run),
  .cut_overflow (out_ch.cut_overflow)
);
`default_nettype wire

### dv/polyline_splitter_top_test.sv
`timescale 1ns / 100ps
module polyline_splitter_top_test;
  import pls_pkg::*;

  localparam logic [ModeW-1:0] MODE_ALIAS = 3'd7;
  localparam longint U = 64'd65536;
  localparam longint CMIN = -(64'sd1 <<< 47);
  localparam longint CMAX = (64'sd1 <<< 47) - 1;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [CoordW-1:0] x, y, z, m;
    logic                     first, last;
    logic [LenW-1:0]          plen;
  } vtx_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CoordW-1:0] x, y, z, m;
    logic              last, ovf;
  } pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [LenW-1:0] cfg_wdata;

  pls_in_if in_ch();
  pls_out_if out_ch();

  polyline_splitter_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pt_t pending_pts[$];
  int err_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;

  // predictor state
  logic [ModeW-1:0] sp_mode;
  logic [LenW-1:0] sp_piece;
  logic [DivCntW-1:0] sp_divs;
  logic signed [CoordW-1:0] pv_x, pv_y, pv_z, pv_m;
  longint unsigned carried, target, dflt;
  bit sw_pend, halted;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic longint unsigned muldiv(longint unsigned a, longint unsigned b,
                                             longint unsigned c);
    logic [127:0] p;
    if (c == 0) return 0;
    p = {64'b0, a} * {64'b0, b};
    p = p / {64'b0, c};
    return p[63:0];
  endfunction

  function automatic longint unsigned seg_len(longint unsigned mx, longint unsigned my);
    logic [127:0] s, cc;
    longint unsigned r, cand;
    if (mx > LenMax || my > LenMax) return LenMax;
    s = {64'b0, mx} * {64'b0, mx} + {64'b0, my} * {64'b0, my};
    r = 0;
    for (int b = 48; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      cc = {64'b0, cand} * {64'b0, cand};
      if (cc <= s) r = cand;
    end
    return (r > LenMax) ? LenMax : r;
  endfunction

  function automatic longint unsigned absdiff(longint a, longint b);
    return (a <= b) ? longint'(b - a) : longint'(a - b);
  endfunction

  function automatic logic [CoordW-1:0] interp(longint a, longint b,
                                               longint unsigned cut_pos,
                                               longint unsigned len);
    longint r;
    if (a <= b) r = a + longint'(muldiv(b - a, cut_pos, len));
    else r = a - longint'(muldiv(a - b, cut_pos, len));
    return r[CoordW-1:0];
  endfunction

  function automatic longint unsigned first_target(logic [LenW-1:0] plen);
    longint unsigned p;
    p = plen;
    case (sp_mode)
      MODE_EVEN:  return (sp_piece != 0) ? (p % sp_piece) >> 1 : 0;
      MODE_COUNT: return p / (longint'(sp_divs) + 1);
      MODE_HALF:  return ((sp_divs != 0) ? p / sp_divs : longint'(LenMax)) >> 1;
      default:    return sp_piece;
    endcase
  endfunction

  task automatic push_pt(input logic [1:0] kind, input logic [CoordW-1:0] x, y, z, m,
                         input logic last, ovf);
    pt_t p;
    p.kind = kind; p.x = x; p.y = y; p.z = z; p.m = m; p.last = last; p.ovf = ovf;
    pending_pts.push_back(p);
  endtask

  task automatic predict_split(input vtx_t v);
    longint unsigned len, rem, stepd, cut_pos;
    longint ax, ay, az, am, bx, by, bz, bm;
    int n;
    bit ovf;
    if (halted) begin
      push_pt(KIND_ERROR, '0, '0, '0, '0, 1'b1, 1'b0);
      return;
    end
    if (v.first) begin
      target = first_target(v.plen);
      case (sp_mode)
        MODE_CARRY: begin sw_pend = 0; dflt = sp_piece; end
        MODE_EVEN:  begin sw_pend = 1; carried = 0; dflt = sp_piece; end
        MODE_COUNT: begin sw_pend = 0; carried = 0; dflt = target; end
        MODE_HALF: begin
          sw_pend = 1; carried = 0;
          dflt = (sp_divs != 0) ? longint'(v.plen) / sp_divs : longint'(LenMax);
        end
        default: begin sw_pend = 0; carried = 0; dflt = sp_piece; end
      endcase
      pv_x = v.x; pv_y = v.y; pv_z = v.z; pv_m = v.m;
      if (!v.last) push_pt(KIND_START, v.x, v.y, v.z, v.m, 1'b1, 1'b0);
      return;
    end
    if (target == 0) begin
      halted = 1;
      push_pt(KIND_ERROR, '0, '0, '0, '0, 1'b1, 1'b0);
      return;
    end
    ax = pv_x; ay = pv_y; az = pv_z; am = pv_m;
    bx = v.x; by = v.y; bz = v.z; bm = v.m;
    len = seg_len(absdiff(ax, bx), absdiff(ay, by));
    rem = len;
    n = 0;
    ovf = 0;
    while (rem + carried > target) begin
      if (n == MaxCuts) begin
        ovf = 1;
        rem = ((rem - 1) % target) + 1;
        carried = 0;
        break;
      end
      stepd = (carried < target) ? target - carried : 0;
      rem -= stepd;
      carried = 0;
      cut_pos = len - rem;
      push_pt(KIND_CUT, interp(ax, bx, cut_pos, len), interp(ay, by, cut_pos, len),
              interp(az, bz, cut_pos, len), interp(am, bm, cut_pos, len), 1'b0, 1'b0);
      n++;
      if (sw_pend) begin
        sw_pend = 0;
        target = dflt;
      end
    end
    push_pt(KIND_VERTEX, v.x, v.y, v.z, v.m, 1'b1, ovf);
    carried += rem;
    if (carried > LenMax) carried = LenMax;
    pv_x = v.x; pv_y = v.y; pv_z = v.z; pv_m = v.m;
  endtask

  task automatic send_vtx(input longint x, y, z, m, input bit first, last,
                          input logic [LenW-1:0] plen);
    vtx_t v;
    v.x = x[CoordW-1:0]; v.y = y[CoordW-1:0]; v.z = z[CoordW-1:0]; v.m = m[CoordW-1:0];
    v.first = first; v.last = last; v.plen = plen;
    predict_split(v);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x <= v.x; in_ch.y <= v.y; in_ch.z <= v.z; in_ch.m <= v.m;
    in_ch.first_in_part <= v.first;
    in_ch.last_in_part <= v.last;
    in_ch.part_length <= v.plen;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // called in the step of the last accept, so valid drops without a repeat word
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPLIT_MODE:     sp_mode = data[ModeW-1:0];
      CFG_PIECE_LENGTH:   sp_piece = data;
      CFG_DIVISION_COUNT: sp_divs = data[DivCntW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  task automatic rand_part(input int nv, input int span, inout int sent);
    longint cx, cy, d;
    logic [LenW-1:0] plen;
    longint unsigned lim;
    cx = longint'(signed'(rand48()));
    cy = longint'(signed'(rand48()));
    do begin
      if (sp_mode == MODE_COUNT || sp_mode == MODE_HALF)
        plen = (longint'(sp_divs) + 1) * $urandom_range(2, 6) * U + $urandom_range(0, 65535);
      else if (sp_mode == MODE_EVEN) begin
        lim = longint'(sp_piece) * 8 + 1;
        plen = longint'(rand48()) % lim;
      end else
        plen = rand48();
    end while (first_target(plen) == 0);
    d = longint'(span) * U;
    for (int i = 0; i < nv; i++) begin
      if (i != 0) begin
        cx += longint'($urandom_range(0, 2 * d)) - d;
        cy += longint'($urandom_range(0, 2 * d)) - d;
      end
      send_vtx(cx, cy, longint'(signed'(rand48())), longint'(signed'(rand48())),
               i == 0, i == nv - 1, plen);
      sent++;
    end
  endtask

  task automatic test_directed();
    int sent;
    sent = 0;
    // default setup: full start, 5 units
    send_vtx(0, 0, CMIN, CMAX, 1, 0, '1);
    send_vtx(12 * U, 0, CMAX, CMIN, 0, 0, '0);
    send_vtx(12 * U, 3 * U, 0, 0, 0, 1, '0);
    send_vtx(7 * U, 7 * U, 1, 1, 1, 1, 10 * U);  // lone vertex part
    send_vtx(2 * U, 7 * U, -1, -1, 0, 1, '0);    // no first mark: continues
    write_cfg(CFG_SPLIT_MODE, MODE_CARRY);
    write_cfg(CFG_PIECE_LENGTH, 8 * U);
    send_vtx(0, 0, 0, 0, 1, 0, '0);
    send_vtx(6 * U, 0, 0, 0, 0, 1, '0);
    write_cfg(CFG_PIECE_LENGTH, 2 * U);           // carry now above target
    send_vtx(0, 0, 5, 5, 1, 0, '0);
    send_vtx(0, -5 * U, 9, 9, 0, 1, '0);
    write_cfg(CFG_SPLIT_MODE, MODE_EVEN);
    write_cfg(CFG_PIECE_LENGTH, 3 * U);
    send_vtx(U, U, 0, 0, 1, 0, 11 * U);
    send_vtx(9 * U, U, 4 * U, -4 * U, 0, 1, '0);
    write_cfg(CFG_SPLIT_MODE, MODE_COUNT);
    write_cfg(CFG_DIVISION_COUNT, 3);
    send_vtx(0, 0, 0, 0, 1, 0, 10 * U);
    send_vtx(-10 * U, 0, 100, -100, 0, 1, '0);
    write_cfg(CFG_DIVISION_COUNT, 16'hFFFF);
    send_vtx(0, 0, 0, 0, 1, 0, '1);
    send_vtx(3 * U, 4 * U, 0, 0, 0, 1, '0);
    write_cfg(CFG_SPLIT_MODE, MODE_HALF);
    write_cfg(CFG_DIVISION_COUNT, 0);             // saturated quotient
    send_vtx(0, 0, 0, 0, 1, 0, 10 * U);
    send_vtx(9 * U, 9 * U, 0, 0, 0, 1, '0);
    write_cfg(CFG_DIVISION_COUNT, 4);
    send_vtx(0, 0, 0, 0, 1, 0, 8 * U);
    send_vtx(0, 8 * U, U, U, 0, 1, '0);
    write_cfg(CFG_SPLIT_MODE, MODE_ALIAS);
    write_cfg(CFG_PIECE_LENGTH, U);
    send_vtx(0, 0, 0, 0, 1, 0, '0);
    send_vtx(70 * U, 0, 70 * U, 7, 0, 1, '0);     // more cuts than the bound
    write_cfg(CFG_SPLIT_MODE, MODE_FULL);
    write_cfg(CFG_PIECE_LENGTH, LenMax);
    send_vtx(CMIN, 0, CMIN, CMAX, 1, 0, '0);
    send_vtx(CMAX, CMAX, CMAX, CMIN, 0, 0, '0);  // saturated length
    send_vtx(CMAX - U, CMAX, 0, 0, 0, 1, '0);
  endtask

  task automatic test_random();
    int sent;
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin snd_idle_pct = 33; rcv_idle_pct = 45; end
        1: begin snd_idle_pct = 45; rcv_idle_pct = 33; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < 40) begin
        write_cfg(CFG_SPLIT_MODE, $urandom_range(0, 7));
        write_cfg(CFG_PIECE_LENGTH, $urandom_range(1, 4) * U + $urandom_range(0, 65535));
        write_cfg(CFG_DIVISION_COUNT, $urandom_range(0, 6));
        for (int p = 0; p < 3; p++) rand_part($urandom_range(1, 6), 5, sent);
      end
    end
  endtask

  task automatic test_backpressure();
    int sent;
    sent = 0;
    write_cfg(CFG_SPLIT_MODE, MODE_FULL);
    write_cfg(CFG_PIECE_LENGTH, 2 * U);
    hold_tog = ~hold_tog;
    rand_part(8, 4, sent);
    settle();
  endtask

  task automatic test_halt();
    int sent;
    sent = 0;
    write_cfg(CFG_SPLIT_MODE, MODE_EVEN);
    write_cfg(CFG_PIECE_LENGTH, '0);
    send_vtx(0, 0, 0, 0, 1, 0, 5 * U);
    send_vtx(U, U, 0, 0, 0, 0, '0);
    for (int i = 0; i < 4; i++)
      send_vtx(longint'(signed'(rand48())), longint'(signed'(rand48())), 0, 0,
               $urandom_range(0, 1), $urandom_range(0, 1), rand48());
  endtask

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    pt_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pts.size() == 0)
        report_mismatch($sformatf("unexpected word kind %0d", out_ch.point_kind));
      else begin
        e = pending_pts.pop_front();
        if (out_ch.point_kind !== e.kind || out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
            out_ch.out_z !== e.z || out_ch.out_m !== e.m ||
            out_ch.last_of_run !== e.last || out_ch.cut_overflow !== e.ovf)
          report_mismatch($sformatf(
            "got k%0d x%h y%h z%h m%h l%b o%b exp k%0d x%h y%h z%h m%h l%b o%b",
            out_ch.point_kind, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_m,
            out_ch.last_of_run, out_ch.cut_overflow,
            e.kind, e.x, e.y, e.z, e.m, e.last, e.ovf));
      end
    end
  end

  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x = '0; in_ch.y = '0; in_ch.z = '0; in_ch.m = '0;
    in_ch.first_in_part = 1'b0;
    in_ch.last_in_part = 1'b0;
    in_ch.part_length = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sp_mode = MODE_FULL;
    sp_piece = PieceLengthRst;
    sp_divs = DivCountRst;
    pv_x = '0; pv_y = '0; pv_z = '0; pv_m = '0;
    carried = 0; target = 0; dflt = 0;
    sw_pend = 0; halted = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_halt();
    settle();
    if (err_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

### polyline_splitter_top.f
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_in_if.sv
rtl/pls_out_if.sv
rtl/pls_unit.sv
rtl/polyline_splitter_top.sv
rtl/pls_checker.sv
dv/polyline_splitter_top_test.sv
